@@ hdl/cbl_pkg.sv @@
// Shared types and codes for the byte-bus CSMA/CD media access controller.
package cbl_pkg;

  localparam int unsigned RESET_COLLISION_BITS = 15;
  localparam int unsigned RESET_CARRIER_BITS   = 20;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_RX   = 2'd1,
    CMD_PKT  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_RX   = 3'd1,
    MODE_TX   = 3'd2,
    MODE_COLL = 3'd3,
    MODE_CDB  = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_ACCEPTED = 3'd1,
    ST_CD_BACK  = 3'd2,
    ST_PRIO     = 3'd3,
    ST_BUSY     = 3'd4,
    ST_DONE     = 3'd5,
    ST_COLL     = 3'd6,
    ST_QFULL    = 3'd7
  } status_t;

  typedef enum logic {
    REG_COLLISION_BITS = 1'b0,
    REG_CARRIER_BITS   = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] byte_value;
    logic       first_byte;
    logic       last_byte;
    logic [7:0] prio_delay;
    logic       line_busy;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        rx_valid;
    logic [7:0]  rx_byte;
    logic        break_drive;
    logic [2:0]  mac_mode;
    logic [15:0] collision_total;
  } out_item_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       flush;
    logic [7:0] wdata;
  } queue_ctl_t;

  typedef struct packed {
    logic       empty;
    logic       full;
    logic [7:0] head_data;
  } queue_stat_t;

endpackage

@@ hdl/cbl_queue.sv @@
// Send queue: circular buffer memory with prefetched head byte.
module cbl_queue #(
  parameter int unsigned QUEUE_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cbl_pkg::queue_ctl_t ctl,
  output cbl_pkg::queue_stat_t stat
);
  import cbl_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [7:0]    mem [QUEUE_DEPTH];
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [7:0]    rd_r;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (ctl.flush) begin
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
    end else if (ctl.pop) begin
      head_nxt  = (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + AW'(1);
      count_nxt = count_r - CW'(1);
    end else if (ctl.push) begin
      tail_nxt  = (tail_r == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + AW'(1);
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // forward a write that lands on the next head address
  always_ff @(posedge clk) begin
    if (ctl.push && !ctl.flush) begin
      mem[tail_r] <= ctl.wdata;
    end
    if (ctl.push && !ctl.flush && (tail_r == head_nxt)) begin
      rd_r <= ctl.wdata;
    end else begin
      rd_r <= mem[head_nxt];
    end
  end

  assign stat.empty     = (count_r == '0);
  assign stat.full      = (count_r == CW'(QUEUE_DEPTH));
  assign stat.head_data = rd_r;

endmodule

@@ hdl/cbl_core.sv @@
// Mode sequencer, timers, admission, echo check; one transaction per step cycle.
module cbl_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  cbl_pkg::in_item_t    item,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [7:0]           cfg_wdata,
  input  cbl_pkg::queue_stat_t qstat,
  output cbl_pkg::queue_ctl_t  qctl,
  output cbl_pkg::out_item_t   result
);
  import cbl_pkg::*;

  mode_t       mode_r, mode_nxt;
  logic [7:0]  timer_r, timer_nxt;
  logic        await_r, await_nxt;
  logic [7:0]  last_sent_r, last_sent_nxt;
  logic        open_r, open_nxt;
  logic [15:0] coll_cnt_r, coll_cnt_nxt;
  logic [7:0]  collision_bits_r;
  logic [7:0]  carrier_bits_r;

  queue_ctl_t  qc;
  status_t     st;
  logic        coll;
  logic        take;
  logic [7:0]  timer_dec;
  logic [7:0]  elapsed;

  always_comb begin
    mode_nxt      = mode_r;
    timer_nxt     = timer_r;
    await_nxt     = await_r;
    last_sent_nxt = last_sent_r;
    open_nxt      = open_r;
    coll_cnt_nxt  = coll_cnt_r;
    qc            = '0;
    qc.wdata      = item.byte_value;
    st            = ST_NONE;
    coll          = 1'b0;
    take          = 1'b0;
    result        = '0;
    timer_dec     = (timer_r != 8'd0) ? timer_r - 8'd1 : 8'd0;
    elapsed       = (timer_r > carrier_bits_r) ? 8'd0 : carrier_bits_r - timer_r;

    case (item.cmd)
      CMD_TICK: begin
        case (mode_r)
          MODE_RX: begin
            if (!item.line_busy) begin
              mode_nxt  = MODE_CDB;
              timer_nxt = carrier_bits_r;
            end
          end
          MODE_CDB: begin
            timer_nxt = timer_dec;
            if (timer_dec == 8'd0) begin
              mode_nxt = MODE_IDLE;
            end
          end
          MODE_COLL: begin
            timer_nxt = timer_dec;
            if (timer_dec == 8'd0) begin
              mode_nxt  = MODE_CDB;
              timer_nxt = carrier_bits_r;
            end
          end
          MODE_IDLE: begin
            if (!qstat.empty && !open_r) begin
              if (item.line_busy) begin
                coll = 1'b1;
              end else begin
                mode_nxt        = MODE_TX;
                qc.pop          = 1'b1;
                last_sent_nxt   = qstat.head_data;
                await_nxt       = 1'b1;
                result.tx_valid = 1'b1;
                result.tx_byte  = qstat.head_data;
              end
            end
          end
          default: begin
          end
        endcase
      end
      CMD_RX: begin
        if (mode_r == MODE_TX && await_r) begin
          await_nxt = 1'b0;
          if (item.byte_value != last_sent_r) begin
            coll = 1'b1;
          end else if (!qstat.empty) begin
            qc.pop          = 1'b1;
            last_sent_nxt   = qstat.head_data;
            await_nxt       = 1'b1;
            result.tx_valid = 1'b1;
            result.tx_byte  = qstat.head_data;
          end else begin
            mode_nxt  = MODE_CDB;
            timer_nxt = carrier_bits_r;
            st        = ST_DONE;
          end
        end else begin
          await_nxt       = 1'b0;
          mode_nxt        = MODE_RX;
          result.rx_valid = 1'b1;
          result.rx_byte  = item.byte_value;
        end
      end
      CMD_PKT: begin
        if (item.first_byte) begin
          if (mode_r == MODE_CDB) begin
            if (elapsed >= item.prio_delay) begin
              mode_nxt = MODE_IDLE;
              take     = 1'b1;
            end else begin
              st = (timer_r != 8'd0) ? ST_CD_BACK : ST_PRIO;
            end
          end else if (mode_r == MODE_IDLE) begin
            take = 1'b1;
          end else begin
            st = ST_BUSY;
          end
          if (take) begin
            open_nxt = 1'b1;
          end
        end else if (open_r) begin
          if (mode_r == MODE_IDLE || mode_r == MODE_TX) begin
            take = 1'b1;
          end else begin
            qc.flush = 1'b1;
            open_nxt = 1'b0;
            st       = ST_BUSY;
          end
        end
        if (take) begin
          if (qstat.full) begin
            st = ST_QFULL;
          end else begin
            qc.push = 1'b1;
            st      = ST_ACCEPTED;
          end
          if (item.last_byte) begin
            open_nxt = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase

    if (coll) begin
      qc.flush     = 1'b1;
      await_nxt    = 1'b0;
      open_nxt     = 1'b0;
      mode_nxt     = MODE_COLL;
      timer_nxt    = collision_bits_r;
      coll_cnt_nxt = coll_cnt_r + 16'd1;
      st           = ST_COLL;
    end

    result.status          = st;
    result.break_drive     = (mode_nxt == MODE_COLL);
    result.mac_mode        = mode_nxt;
    result.collision_total = coll_cnt_nxt;
  end

  assign qctl = step ? qc : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      timer_r     <= '0;
      await_r     <= 1'b0;
      last_sent_r <= '0;
      open_r      <= 1'b0;
      coll_cnt_r  <= '0;
    end else if (step) begin
      mode_r      <= mode_nxt;
      timer_r     <= timer_nxt;
      await_r     <= await_nxt;
      last_sent_r <= last_sent_nxt;
      open_r      <= open_nxt;
      coll_cnt_r  <= coll_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collision_bits_r <= 8'(RESET_COLLISION_BITS);
      carrier_bits_r   <= 8'(RESET_CARRIER_BITS);
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_COLLISION_BITS: collision_bits_r <= cfg_wdata;
        REG_CARRIER_BITS:   carrier_bits_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

endmodule

@@ hdl/csma_cd_byte_link_mac.sv @@
// Top level of the byte-bus CSMA/CD media access controller.
// One transaction (bit tick, received byte or packet byte) is taken every clock
// cycle while in_stall is low and produces exactly one result transaction: the
// input register feeds the mode sequencer, and its result lands in the output
// register, which lets the next input be taken while a result waits on
// out_stall. The send queue is a QUEUE_DEPTH-entry memory whose head byte is
// prefetched into a register, so a pop never waits on a memory read. Reset
// clears pointers, counters and sequencer state, reloads the timing registers;
// queue contents are unknown until written and no clearing pass runs.
module csma_cd_byte_link_mac #(
  parameter int unsigned QUEUE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cbl_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cbl_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_wdata
);
  import cbl_pkg::*;

  logic        in_valid_r;
  in_item_t    in_item_r;
  logic        out_valid_r;
  out_item_t   out_item_r;
  logic        adv;
  queue_ctl_t  qctl;
  queue_stat_t qstat;
  out_item_t   result;

  assign adv      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r <= result;
    end
  end

  cbl_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .item      (in_item_r),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .qstat     (qstat),
    .qctl      (qctl),
    .result    (result)
  );

  cbl_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (qctl),
    .stat  (qstat)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

@@ hdl/cbl_checker.sv @@
// Port-level assertions for the MAC top level and their bind.
module cbl_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input cbl_pkg::out_item_t out_data
);
  import cbl_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_break_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.break_drive == (out_data.mac_mode == MODE_COLL))
    else $error("break drive disagrees with mode");

  a_idle_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.tx_valid || out_data.tx_byte == 8'd0) &&
                  (out_data.rx_valid || out_data.rx_byte == 8'd0))
    else $error("byte field set without its valid");

  a_coll_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_COLL |->
      out_data.mac_mode == MODE_COLL && !out_data.tx_valid)
    else $error("collision status outside collision mode");

endmodule

bind csma_cd_byte_link_mac cbl_checker u_cbl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ bench/testbench.sv @@
// Self-checking testbench for the byte-bus CSMA/CD media access controller.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cbl_pkg::*;

  localparam int          QDEPTH      = 256;
  localparam int          QAW         = $clog2(QDEPTH);
  localparam int          CYCLE_LIMIT = 400000;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_we;
  logic        cfg_index;
  logic [7:0]  cfg_wdata;

  csma_cd_byte_link_mac #(.QUEUE_DEPTH(QDEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // MAC state as predicted
  mode_t        mac_mode_q  = MODE_IDLE;
  logic [7:0]   bit_tmr     = '0;
  logic [7:0]   sendq [QDEPTH];
  int unsigned  qhead       = 0;
  int unsigned  qcount      = 0;
  bit           echo_wait   = 1'b0;
  logic [7:0]   sent_byte   = '0;
  bit           pkt_open    = 1'b0;
  logic [15:0]  coll_total  = '0;
  logic [7:0]   coll_bits   = 8'(RESET_COLLISION_BITS);
  logic [7:0]   carr_bits   = 8'(RESET_CARRIER_BITS);

  in_item_t     pend_q [$];
  out_item_t    mac_results_due [$];
  int           items_made  = 0;
  int           made_total  = 0;
  int           taken_total = 0;
  int           fails       = 0;
  int           cycles      = 0;
  int           in_gap      = 0;
  int           out_gap     = 0;
  int           hold_left   = 0;
  bit           in_took     = 1'b0;
  bit           out_took    = 1'b0;
  bit           hold_req    = 1'b0;
  bit           in_calm     = 1'b0;
  bit           out_calm    = 1'b0;

  function automatic int draw_gap(bit calm);
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 15);
  endfunction

  function automatic void start_backoff();
    mac_mode_q = MODE_CDB;
    bit_tmr    = carr_bits;
  endfunction

  function automatic void start_collision();
    qhead      = 0;
    qcount     = 0;
    echo_wait  = 1'b0;
    pkt_open   = 1'b0;
    mac_mode_q = MODE_COLL;
    bit_tmr    = coll_bits;
    coll_total = coll_total + 16'd1;
  endfunction

  function automatic logic [7:0] pop_byte();
    logic [7:0] v;
    v      = sendq[QAW'(qhead)];
    qhead  = (qhead + 1) % QDEPTH;
    qcount = qcount - 1;
    return v;
  endfunction

  function automatic out_item_t mac_step(in_item_t it);
    out_item_t  r;
    bit         take;
    logic [7:0] elapsed;
    r    = '0;
    take = 1'b0;
    case (it.cmd)
      CMD_TICK: begin
        case (mac_mode_q)
          MODE_RX: if (!it.line_busy) start_backoff();
          MODE_CDB: begin
            if (bit_tmr > 0) bit_tmr = bit_tmr - 8'd1;
            if (bit_tmr == 0) mac_mode_q = MODE_IDLE;
          end
          MODE_COLL: begin
            if (bit_tmr > 0) bit_tmr = bit_tmr - 8'd1;
            if (bit_tmr == 0) start_backoff();
          end
          MODE_IDLE: begin
            if (qcount > 0 && !pkt_open) begin
              if (it.line_busy) begin
                start_collision();
                r.status = ST_COLL;
              end else begin
                mac_mode_q = MODE_TX;
                sent_byte  = pop_byte();
                echo_wait  = 1'b1;
                r.tx_valid = 1'b1;
                r.tx_byte  = sent_byte;
              end
            end
          end
          default: ;
        endcase
      end
      CMD_RX: begin
        if (mac_mode_q == MODE_TX && echo_wait) begin
          echo_wait = 1'b0;
          if (it.byte_value != sent_byte) begin
            start_collision();
            r.status = ST_COLL;
          end else if (qcount > 0) begin
            sent_byte  = pop_byte();
            echo_wait  = 1'b1;
            r.tx_valid = 1'b1;
            r.tx_byte  = sent_byte;
          end else begin
            start_backoff();
            r.status = ST_DONE;
          end
        end else begin
          echo_wait  = 1'b0;
          mac_mode_q = MODE_RX;
          r.rx_valid = 1'b1;
          r.rx_byte  = it.byte_value;
        end
      end
      CMD_PKT: begin
        if (it.first_byte) begin
          if (mac_mode_q == MODE_CDB) begin
            elapsed = (bit_tmr > carr_bits) ? 8'd0 : carr_bits - bit_tmr;
            if (elapsed >= it.prio_delay) begin
              mac_mode_q = MODE_IDLE;
              take       = 1'b1;
            end else begin
              r.status = (bit_tmr != 0) ? ST_CD_BACK : ST_PRIO;
            end
          end else if (mac_mode_q == MODE_IDLE) begin
            take = 1'b1;
          end else begin
            r.status = ST_BUSY;
          end
          if (take) pkt_open = 1'b1;
        end else if (pkt_open) begin
          if (mac_mode_q == MODE_IDLE || mac_mode_q == MODE_TX) begin
            take = 1'b1;
          end else begin
            qhead    = 0;
            qcount   = 0;
            pkt_open = 1'b0;
            r.status = ST_BUSY;
          end
        end
        if (take) begin
          if (qcount >= QDEPTH) begin
            r.status = ST_QFULL;
          end else begin
            sendq[QAW'((qhead + qcount) % QDEPTH)] = it.byte_value;
            qcount   = qcount + 1;
            r.status = ST_ACCEPTED;
          end
          if (it.last_byte) pkt_open = 1'b0;
        end
      end
      default: ;
    endcase
    r.break_drive     = (mac_mode_q == MODE_COLL);
    r.mac_mode        = mac_mode_q;
    r.collision_total = coll_total;
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endfunction

  function automatic void push_raw(in_item_t it);
    pend_q.push_back(it);
    made_total++;
    if (it.cmd != CMD_UNUSED) items_made++;
  endfunction

  function automatic void push_tick(bit busy);
    in_item_t it;
    it            = in_item_t'(21'($urandom));
    it.cmd        = CMD_TICK;
    it.line_busy  = busy;
    push_raw(it);
  endfunction

  function automatic void push_rx(logic [7:0] v);
    in_item_t it;
    it            = in_item_t'(21'($urandom));
    it.cmd        = CMD_RX;
    it.byte_value = v;
    push_raw(it);
  endfunction

  function automatic void push_pkt(logic [7:0] v, bit f, bit l, logic [7:0] p);
    in_item_t it;
    it            = in_item_t'(21'($urandom));
    it.cmd        = CMD_PKT;
    it.byte_value = v;
    it.first_byte = f;
    it.last_byte  = l;
    it.prio_delay = p;
    push_raw(it);
  endfunction

  function automatic void add_send_flow();
    int         n;
    logic [7:0] b [6];
    logic [7:0] pd;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) b[3'(i)] = 8'($urandom_range(0, 255));
    pd = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 4));
    if ($urandom_range(0, 1)) push_tick(1'b0);
    for (int i = 0; i < n; i++) begin
      push_pkt(b[3'(i)], i == 0, i == n - 1, (i == 0) ? pd : 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 7) == 0) push_tick(1'($urandom_range(0, 1)));
    end
    push_tick($urandom_range(0, 9) == 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) push_tick(1'($urandom_range(0, 1)));
      if ($urandom_range(0, 14) == 0) push_rx(b[3'(i)] ^ 8'($urandom_range(1, 255)));
      else push_rx(b[3'(i)]);
    end
    repeat ($urandom_range(0, 3)) push_tick(1'b0);
  endfunction

  function automatic void add_long_packet();
    repeat (3) push_rx(8'($urandom_range(0, 255)));
    push_tick(1'b0);
    for (int i = 0; i < QDEPTH + 4; i++)
      push_pkt(8'($urandom_range(0, 255)), i == 0, i == QDEPTH + 3, 8'd0);
  endfunction

  function automatic void add_random(int target);
    logic [20:0] raw;
    while (items_made < target) begin
      case ($urandom_range(0, 9))
        7: begin
          repeat ($urandom_range(1, 3)) begin
            raw = 21'($urandom);
            push_raw(in_item_t'(raw));
          end
        end
        8: repeat ($urandom_range(1, 40)) push_tick($urandom_range(0, 5) == 0);
        9: repeat ($urandom_range(1, 4)) push_rx(8'($urandom_range(0, 255)));
        default: add_send_flow();
      endcase
    end
  endfunction

  task automatic wait_quiet();
    do @(negedge clk);
    while (taken_total != made_total || mac_results_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // drive input transactions
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
    end else begin
      in_took = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pend_q.size() > 0) begin
        in_data  <= pend_q.pop_front();
        in_valid <= 1'b1;
        in_gap   = draw_gap(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // stall result transactions
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 300;
    end
    if (out_took) begin
      out_took = 1'b0;
      out_gap  = draw_gap(out_calm);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // check results, then capture configuration writes and input transactions
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else if (rst_n) begin
      if (out_valid && !out_stall) begin
        out_took = 1'b1;
        if (mac_results_due.size() == 0) begin
          $error("unexpected result transaction");
          fails++;
        end else begin
          out_item_t want;
          want = mac_results_due.pop_front();
          check_field("status", 16'(want.status), 16'(out_data.status));
          check_field("tx_valid", 16'(want.tx_valid), 16'(out_data.tx_valid));
          check_field("tx_byte", 16'(want.tx_byte), 16'(out_data.tx_byte));
          check_field("rx_valid", 16'(want.rx_valid), 16'(out_data.rx_valid));
          check_field("rx_byte", 16'(want.rx_byte), 16'(out_data.rx_byte));
          check_field("break_drive", 16'(want.break_drive), 16'(out_data.break_drive));
          check_field("mac_mode", 16'(want.mac_mode), 16'(out_data.mac_mode));
          check_field("collision_total", want.collision_total, out_data.collision_total);
        end
      end
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_COLLISION_BITS: coll_bits = cfg_wdata;
          REG_CARRIER_BITS:   carr_bits = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        mac_results_due.push_back(mac_step(in_data));
        taken_total++;
        in_took = 1'b1;
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = REG_COLLISION_BITS;
    cfg_wdata = '0;

    push_tick(1'b0);
    push_raw(in_item_t'({CMD_UNUSED, 19'h7FFFF}));
    push_pkt(8'hC3, 1'b0, 1'b1, 8'd0);
    push_rx(8'hFF);
    push_pkt(8'h12, 1'b1, 1'b1, 8'd0);
    push_tick(1'b1);
    push_tick(1'b0);
    push_pkt(8'hFF, 1'b1, 1'b1, 8'hFF);
    push_pkt(8'h00, 1'b1, 1'b0, 8'd0);
    push_pkt(8'hA5, 1'b0, 1'b1, 8'hFF);
    push_tick(1'b1);
    push_pkt(8'h44, 1'b1, 1'b1, 8'd0);
    push_rx(8'h3C);
    push_tick(1'b0);
    push_pkt(8'h5A, 1'b1, 1'b1, 8'd0);
    push_tick(1'b0);
    push_tick(1'b1);
    push_rx(8'h5A);
    push_pkt(8'h11, 1'b1, 1'b0, 8'd0);
    push_pkt(8'h33, 1'b1, 1'b0, 8'd0);
    push_pkt(8'h22, 1'b0, 1'b1, 8'd0);
    push_tick(1'b0);
    push_rx(8'h11);
    push_rx(8'h34);
    push_rx(8'h00);
    push_tick(1'b0);
    push_pkt(8'h77, 1'b1, 1'b0, 8'd0);
    push_rx(8'h80);
    push_pkt(8'h99, 1'b0, 1'b1, 8'd0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_random(100);
    wait_quiet();

    write_reg(REG_COLLISION_BITS, 8'd1);
    write_reg(REG_CARRIER_BITS, 8'd1);
    in_calm = 1'b1;
    add_random(160);
    @(posedge clk);
    hold_req = 1'b1;
    wait_quiet();
    in_calm = 1'b0;

    write_reg(REG_COLLISION_BITS, 8'd255);
    write_reg(REG_CARRIER_BITS, 8'd255);
    add_long_packet();
    add_random(items_made + 50);
    wait_quiet();

    write_reg(REG_COLLISION_BITS, 8'($urandom_range(2, 40)));
    write_reg(REG_CARRIER_BITS, 8'($urandom_range(2, 40)));
    in_calm  = 1'b1;
    out_calm = 1'b1;
    add_random(items_made + 30);
    wait_quiet();
    in_calm  = 1'b0;
    out_calm = 1'b0;
    add_long_packet();
    add_random(items_made + 40);
    wait_quiet();

    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
